// ===== sv/clpm_pkg.sv =====
// Package for the command line prefix matcher.
// Holds item kinds, verdict codes and the command name table.
// Used by the front end, back end, top level and checker; depends on nothing.
package clpm_pkg;

    localparam int unsigned TABLE_SIZE    = 11;
    localparam int unsigned COMMAND_COUNT = 11;
    localparam int unsigned ACTIVE_COUNT  =
        (COMMAND_COUNT < TABLE_SIZE) ? COMMAND_COUNT : TABLE_SIZE;
    localparam int unsigned MAX_FULL      = 10;
    localparam int unsigned MAX_ABBR      = 2;
    localparam int unsigned MIN_PREFIX    = 2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [1:0] V_NONE    = 2'd0;
    localparam logic [1:0] V_MATCH   = 2'd1;
    localparam logic [1:0] V_AMBIG   = 2'd2;
    localparam logic [1:0] V_UNKNOWN = 2'd3;

    typedef enum logic [1:0] {
        K_CHAR,
        K_RUB,
        K_END
    } t_kind;

    typedef struct packed {
        logic [7:0] ch;
        t_kind      kind;
    } t_item;

    localparam logic [MAX_FULL*8-1:0] FULL_TXT [TABLE_SIZE] = '{
        "help", "update", "download", "info", "erase", "reset",
        "jump", "extinfo", "extbackup", "extrestore", "extlist"
    };
    localparam logic [3:0] FULL_LEN [TABLE_SIZE] = '{
        4'd4, 4'd6, 4'd8, 4'd4, 4'd5, 4'd5, 4'd4, 4'd7, 4'd9, 4'd10, 4'd7
    };
    localparam logic [MAX_ABBR*8-1:0] ABBR_TXT [TABLE_SIZE] = '{
        "h", "u", "d", "i", "e", "r", "j", "xi", "xb", "xr", "xl"
    };
    localparam logic [3:0] ABBR_LEN [TABLE_SIZE] = '{
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2
    };

    function automatic logic [7:0] full_char(input int idx, input logic [3:0] pos);
        logic [7:0] res;
        int         sh;
        res = 8'h00;
        sh  = (int'(FULL_LEN[idx]) - 1 - int'(pos)) * 8;
        if (pos < FULL_LEN[idx]) begin
            res = FULL_TXT[idx][sh +: 8];
        end
        return res;
    endfunction

    function automatic logic [7:0] abbr_char(input int idx, input logic [3:0] pos);
        logic [7:0] res;
        int         sh;
        res = 8'h00;
        sh  = (int'(ABBR_LEN[idx]) - 1 - int'(pos)) * 8;
        if (pos < ABBR_LEN[idx]) begin
            res = ABBR_TXT[idx][sh +: 8];
        end
        return res;
    endfunction

endpackage

// ===== sv/clpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stores the typed line; depends on nothing.
module clpm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 255
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== sv/clpm_front.sv =====
// Front end: accepts received bytes, classifies them and queues them.
// Two-entry queue toward the back end; uses clpm_pkg.
module clpm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [7:0]     i_rx_byte,
    output logic           o_item_vld,
    output clpm_pkg::t_item o_item,
    input  logic           i_pop
);
    import clpm_pkg::*;

    t_item      r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       push;
    t_item      new_item;

    assign o_in_stall = (r_fill == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_item_vld = (r_fill != 2'd0);
    assign o_item     = r_q[r_rd_ptr];

    always_comb begin
        new_item.ch = i_rx_byte;
        unique case (i_rx_byte)
            CH_CR, CH_LF:  new_item.kind = K_END;
            CH_BS, CH_DEL: new_item.kind = K_RUB;
            default:       new_item.kind = K_CHAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wr_ptr] <= new_item;
                r_wr_ptr      <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!push && i_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end
endmodule

// ===== sv/clpm_back.sv =====
// Back end: keeps the line, scans it at line end and judges the command.
// Holds the result register; uses clpm_pkg and clpm_ram.
module clpm_back #(
    parameter int unsigned LINE_CHARS = 255
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_vld,
    input  clpm_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_echo_byte,
    output logic            o_rub_out,
    output logic            o_line_end,
    output logic [1:0]      o_verdict,
    output logic [3:0]      o_command_index
);
    import clpm_pkg::*;

    localparam int unsigned CW = $clog2(LINE_CHARS + 1);
    localparam int unsigned AW = $clog2(LINE_CHARS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_JUDGE
    } t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_count;
    logic [AW-1:0]           r_addr;
    logic                    r_rd_vld;
    logic                    r_started;
    logic [3:0]              r_pos;
    logic [3:0]              r_slen;
    logic [TABLE_SIZE-1:0]   r_hf, r_ha, r_sf, r_sa;
    logic                    r_out_vld;
    logic [7:0]              r_echo;
    logic                    r_rub, r_end;
    logic [1:0]              r_verdict;
    logic [3:0]              r_index;

    logic                    out_free;
    logic                    wr_en;
    logic [7:0]              rd_data;
    logic [7:0]              folded;
    logic [TABLE_SIZE-1:0]   n_hf, n_ha;
    logic [CW-1:0]           cnt_m1;
    logic [1:0]              j_verdict;
    logic [3:0]              j_index;
    logic [3:0]              hits;
    logic                    found;
    logic                    ex;

    assign out_free = !r_out_vld || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && i_item_vld && out_free;
    assign wr_en    = o_pop && (i_item.kind == K_CHAR) && (r_count < CW'(LINE_CHARS));
    assign cnt_m1   = r_count - CW'(1);

    clpm_ram #(
        .WIDTH(8),
        .DEPTH(LINE_CHARS)
    ) u_line_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_data(i_item.ch),
        .i_rd_addr(r_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        folded = rd_data;
        if (rd_data >= CH_UP_A && rd_data <= CH_UP_Z) begin
            folded = rd_data + CASE_OFS;
        end
        for (int i = 0; i < TABLE_SIZE; i++) begin
            n_hf[i] = r_hf[i] && (r_pos < FULL_LEN[i]) && (folded == full_char(i, r_pos));
            n_ha[i] = r_ha[i] && (r_pos < ABBR_LEN[i]) && (folded == abbr_char(i, r_pos));
        end
    end

    always_comb begin
        hits      = 4'd0;
        found     = 1'b0;
        ex        = 1'b0;
        j_verdict = V_UNKNOWN;
        j_index   = 4'd0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (i < ACTIVE_COUNT && r_sf[i]) begin
                hits = hits + 4'd1;
            end
        end
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (!found && i < ACTIVE_COUNT) begin
                ex = (r_sa[i] && r_slen == ABBR_LEN[i]) || (r_sf[i] && r_slen == FULL_LEN[i]);
                if (ex) begin
                    found     = 1'b1;
                    j_verdict = V_MATCH;
                    j_index   = 4'(i);
                end else if (r_slen >= 4'(MIN_PREFIX) && r_sf[i]) begin
                    found = 1'b1;
                    if (hits == 4'd1) begin
                        j_verdict = V_MATCH;
                        j_index   = 4'(i);
                    end else begin
                        j_verdict = V_AMBIG;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            r_rd_vld <= 1'b0;
            if (r_rd_vld && (r_started || rd_data != CH_SPACE)) begin
                r_started <= 1'b1;
                r_hf      <= n_hf;
                r_ha      <= n_ha;
                if (r_pos != 4'(MAX_FULL + 1)) begin
                    r_pos <= r_pos + 4'd1;
                end
                if (rd_data != CH_SPACE) begin
                    r_sf   <= n_hf;
                    r_sa   <= n_ha;
                    r_slen <= (r_pos == 4'(MAX_FULL + 1)) ? r_pos : r_pos + 4'd1;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_echo    <= i_item.ch;
                        r_rub     <= 1'b0;
                        r_end     <= 1'b0;
                        r_verdict <= V_NONE;
                        r_index   <= 4'd0;
                        unique case (i_item.kind)
                            K_CHAR: begin
                                if (r_count < CW'(LINE_CHARS)) begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_out_vld <= 1'b1;
                            end
                            K_RUB: begin
                                if (r_count != '0) begin
                                    r_count <= cnt_m1;
                                    r_rub   <= 1'b1;
                                end
                                r_out_vld <= 1'b1;
                            end
                            K_END: begin
                                r_end <= 1'b1;
                                if (r_count == '0) begin
                                    r_out_vld <= 1'b1;
                                end else begin
                                    r_addr    <= '0;
                                    r_started <= 1'b0;
                                    r_pos     <= 4'd0;
                                    r_slen    <= 4'd0;
                                    r_hf      <= '1;
                                    r_ha      <= '1;
                                    r_sf      <= '1;
                                    r_sa      <= '1;
                                    r_state   <= S_SCAN;
                                end
                            end
                            default: r_out_vld <= 1'b1;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= 1'b1;
                    r_addr   <= r_addr + AW'(1);
                    if (r_addr == cnt_m1[AW-1:0]) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_state <= S_JUDGE;
                end
                S_JUDGE: begin
                    r_verdict <= j_verdict;
                    r_index   <= j_index;
                    r_out_vld <= 1'b1;
                    r_count   <= '0;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_echo_byte     = r_echo;
    assign o_rub_out       = r_rub;
    assign o_line_end      = r_end;
    assign o_verdict       = r_verdict;
    assign o_command_index = r_index;
endmodule

// ===== sv/command_line_prefix_matcher_top.sv =====
// Top level of the command line prefix matcher.
// Joins the front end queue and the back end; uses clpm_pkg.
//
//   channel | direction | handshake                  | payload
//   input   | in        | i_in_valid / o_in_stall    | i_rx_byte
//   output  | out       | o_out_valid / i_out_stall  | o_echo_byte, o_rub_out, o_line_end,
//           |           |                            | o_verdict, o_command_index
//
// Ordinary, backspace and empty line end bytes: one per cycle while the output is not stalled.
// Line end on a non-empty line: the back end reads one stored character
// per cycle from the single read port of the line RAM, then judges the command.
// Reset clears control state only; the line RAM needs no clearing.
// The two-entry queue keeps taking bytes until full while a result waits under output stall.
module command_line_prefix_matcher_top #(
    parameter int unsigned LINE_CHARS = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_echo_byte,
    output logic       o_rub_out,
    output logic       o_line_end,
    output logic [1:0] o_verdict,
    output logic [3:0] o_command_index
);
    import clpm_pkg::*;

    logic  item_vld;
    t_item item;
    logic  pop;

    clpm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_rx_byte (i_rx_byte),
        .o_item_vld(item_vld),
        .o_item    (item),
        .i_pop     (pop)
    );

    clpm_back #(
        .LINE_CHARS(LINE_CHARS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_vld     (item_vld),
        .i_item         (item),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_echo_byte    (o_echo_byte),
        .o_rub_out      (o_rub_out),
        .o_line_end     (o_line_end),
        .o_verdict      (o_verdict),
        .o_command_index(o_command_index)
    );
endmodule

// ===== sv/clpm_checker.sv =====
// Port-level checks for the command line prefix matcher.
// Bound to command_line_prefix_matcher_top; uses clpm_pkg.
module clpm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_echo_byte,
    input logic       o_rub_out,
    input logic       o_line_end,
    input logic [1:0] o_verdict,
    input logic [3:0] o_command_index
);
    import clpm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_echo_byte)
            && $stable(o_verdict) && $stable(o_command_index))
        else $error("result changed under stall");

    a_verdict_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_line_end |-> o_verdict == V_NONE)
        else $error("verdict without line end");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_verdict != V_MATCH |-> o_command_index == 4'd0)
        else $error("index set without match");

    a_rub_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rub_out |-> o_echo_byte == CH_BS || o_echo_byte == CH_DEL)
        else $error("rub-out on ordinary byte");

    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_end |-> !o_rub_out
            && (o_echo_byte == CH_CR || o_echo_byte == CH_LF))
        else $error("line end on wrong byte");
endmodule

bind command_line_prefix_matcher_top clpm_checker u_clpm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_echo_byte    (o_echo_byte),
    .o_rub_out      (o_rub_out),
    .o_line_end     (o_line_end),
    .o_verdict      (o_verdict),
    .o_command_index(o_command_index)
);

// ===== tb/tb_command_line_prefix_matcher_top.sv =====
// Self-checking testbench for command_line_prefix_matcher_top: directed and random
// terminal bytes under idle, stall and hold-off phases, checked against a predictor.
// Depends on clpm_pkg and the top level RTL only.
`timescale 1ns / 100ps

module tb_command_line_prefix_matcher_top;
    import clpm_pkg::*;

    localparam int LINE_CHARS     = 255;
    localparam int CMD_TOTAL      = 11;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic [7:0] echo;
        logic       rub;
        logic       lend;
        logic [1:0] verdict;
        logic [3:0] idx;
    } t_echo_result;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_echo_byte;
    logic       o_rub_out;
    logic       o_line_end;
    logic [1:0] o_verdict;
    logic [3:0] o_command_index;

    string cmd_full [CMD_TOTAL] = '{"help", "update", "download", "info", "erase", "reset",
                                    "jump", "extinfo", "extbackup", "extrestore", "extlist"};
    string cmd_abbr [CMD_TOTAL] = '{"h", "u", "d", "i", "e", "r", "j", "xi", "xb", "xr", "xl"};

    logic [7:0]   line_buf [LINE_CHARS];
    logic [7:0]   trimmed_low [LINE_CHARS];
    int           line_len;
    t_echo_result expected_q [$];
    t_echo_result want_r;

    int in_gap_pct;
    int out_stall_pct;
    int hold_left;
    int in_count;
    int out_count;
    int mismatch_count;
    int idle_cycles;
    int n_match;
    int n_ambig;
    int n_unknown;
    int n_rub;

    command_line_prefix_matcher_top #(
        .LINE_CHARS(LINE_CHARS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_echo_byte    (o_echo_byte),
        .o_rub_out      (o_rub_out),
        .o_line_end     (o_line_end),
        .o_verdict      (o_verdict),
        .o_command_index(o_command_index)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit name_hit(input string t, input int n, input bit whole);
        int i;
        if (whole ? (n != t.len()) : (n > t.len())) begin
            return 1'b0;
        end
        for (i = 0; i < n; i++) begin
            if (trimmed_low[i] != 8'(t[i])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void classify_line(output logic [1:0] v, output logic [3:0] idx);
        int         s;
        int         e;
        int         n;
        int         i;
        int         k;
        int         hits;
        logic [7:0] c;
        s = 0;
        e = line_len;
        while (s < e && line_buf[s] == CH_SPACE) s++;
        while (e > s && line_buf[e-1] == CH_SPACE) e--;
        n = e - s;
        for (i = 0; i < n; i++) begin
            c = line_buf[s+i];
            trimmed_low[i] = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
        end
        v   = V_UNKNOWN;
        idx = 4'd0;
        for (i = 0; i < int'(ACTIVE_COUNT); i++) begin
            if (name_hit(cmd_abbr[i], n, 1'b1) || name_hit(cmd_full[i], n, 1'b1)) begin
                v   = V_MATCH;
                idx = 4'(i);
                return;
            end
            if (n >= int'(MIN_PREFIX) && name_hit(cmd_full[i], n, 1'b0)) begin
                hits = 0;
                for (k = 0; k < int'(ACTIVE_COUNT); k++) begin
                    if (name_hit(cmd_full[k], n, 1'b0)) hits++;
                end
                v   = (hits == 1) ? V_MATCH : V_AMBIG;
                idx = 4'(i);
                return;
            end
        end
    endfunction

    function automatic t_echo_result predict_echo(input logic [7:0] ch);
        t_echo_result r;
        logic [1:0]   v;
        logic [3:0]   idx;
        r.echo    = ch;
        r.rub     = 1'b0;
        r.lend    = 1'b0;
        r.verdict = V_NONE;
        r.idx     = 4'd0;
        if (ch == CH_CR || ch == CH_LF) begin
            r.lend = 1'b1;
            if (line_len > 0) begin
                classify_line(v, idx);
                r.verdict = v;
                r.idx     = (v == V_MATCH) ? idx : 4'd0;
                line_len  = 0;
                if (v == V_MATCH) n_match++;
                else if (v == V_AMBIG) n_ambig++;
                else n_unknown++;
            end
        end else if (ch == CH_BS || ch == CH_DEL) begin
            if (line_len > 0) begin
                line_len--;
                r.rub = 1'b1;
                n_rub++;
            end
        end else if (line_len < LINE_CHARS) begin
            line_buf[line_len] = ch;
            line_len++;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 30) begin
            $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
                     out_count, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        hold_left = (hold_left > 0) ? hold_left - 1 : 0;
        i_out_stall <= (hold_left > 0) || ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            out_count++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, echo", o_echo_byte, 0);
            end else begin
                want_r = expected_q.pop_front();
                if (o_echo_byte !== want_r.echo)
                    report_mismatch("echo_byte", o_echo_byte, want_r.echo);
                if (o_rub_out !== want_r.rub)
                    report_mismatch("rub_out", o_rub_out, want_r.rub);
                if (o_line_end !== want_r.lend)
                    report_mismatch("line_end", o_line_end, want_r.lend);
                if (o_verdict !== want_r.verdict)
                    report_mismatch("verdict", o_verdict, want_r.verdict);
                if (o_command_index !== want_r.idx)
                    report_mismatch("command_index", o_command_index, want_r.idx);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(predict_echo(b));
        in_count++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(8'(s[i]));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_phase(input int gap_pct, input int stall_pct);
        in_gap_pct    = gap_pct;
        out_stall_pct = stall_pct;
    endtask

    task automatic send_command_line();
        logic [7:0] text [$];
        string      word;
        int         sel;
        int         form;
        int         cut;
        int         i;
        logic [7:0] c;
        sel  = $urandom_range(CMD_TOTAL - 1);
        form = $urandom_range(3);
        word = "";
        if (form == 0) begin
            word = cmd_abbr[sel];
        end else if (form == 1) begin
            word = cmd_full[sel];
        end else if (form == 2) begin
            cut  = $urandom_range(cmd_full[sel].len() - 1);
            word = cmd_full[sel].substr(0, cut);
        end
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0) text.push_back(CH_SPACE);
        for (i = 0; i < word.len(); i++) text.push_back(8'(word[i]));
        if (form == 3) begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0) text.push_back(CH_SPACE);
        foreach (text[i]) begin
            c = text[i];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1)) c = c - CASE_OFS;
            if ($urandom_range(9) == 0) begin
                send_byte(8'($urandom_range(8'h61, 8'h7A)));
                send_byte($urandom_range(1) ? CH_BS : CH_DEL);
            end
            send_byte(c);
        end
        send_byte($urandom_range(1) ? CH_CR : CH_LF);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
        send_byte(CH_CR);
    endtask

    task automatic test_directed();
        set_phase(0, 0);
        send_byte(CH_CR);
        send_byte(CH_BS);
        send_text(" Do ");
        send_byte(CH_CR);
        send_text("ex");
        send_byte(CH_LF);
        send_text("hez");
        send_byte(CH_DEL);
        send_text("lp");
        send_byte(CH_LF);
        send_text("  ");
        send_byte(CH_CR);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_CR);
        wait_drained();
    endtask

    task automatic test_random_lines(input int gap_pct, input int stall_pct, input int n_items);
        int start;
        int pick;
        set_phase(gap_pct, stall_pct);
        start = in_count;
        while (in_count - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 75) send_command_line();
            else if (pick < 90) send_noise();
            else if (pick < 95) send_byte($urandom_range(1) ? CH_BS : CH_DEL);
            else send_byte($urandom_range(1) ? CH_CR : CH_LF);
        end
        wait_drained();
    endtask

    task automatic test_line_full();
        set_phase(15, 15);
        repeat (LINE_CHARS + 3) send_byte(8'($urandom_range(8'h21, 8'h7E)));
        send_byte(CH_DEL);
        send_text("qz");
        send_byte(CH_CR);
        wait_drained();
    endtask

    task automatic test_output_hold_off();
        int start;
        set_phase(0, 0);
        hold_left = HOLD_CYCLES;
        start     = in_count;
        while (in_count - start < 40) send_command_line();
        wait_drained();
    endtask

    initial begin
        line_len       = 0;
        hold_left      = 0;
        in_count       = 0;
        out_count      = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        n_match        = 0;
        n_ambig        = 0;
        n_unknown      = 0;
        n_rub          = 0;
        set_phase(0, 0);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_lines(0, 0, 350);
        test_random_lines(87, 0, 350);
        test_random_lines(0, 87, 350);
        test_random_lines(15, 15, 350);
        test_line_full();
        test_output_hold_off();

        set_phase(0, 0);
        repeat (LINE_CHARS + 16) @(posedge i_clk);
        if (expected_q.size() != 0) report_mismatch("results missing", 0, expected_q.size());

        $display("Sent %0d bytes, checked %0d results: %0d matched, %0d ambiguous, %0d unknown",
                 in_count, out_count, n_match, n_ambig, n_unknown);
        $display("Covered %0d rub-outs, a full line and a %0d-cycle output hold-off",
                 n_rub, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
